// ===== hdl/cfc_pkg.sv =====
// Shared types and constants for the continued fraction convergent unit.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = DataW / 2;
  localparam int unsigned OutDataW = 5 * DataW;

  localparam logic [DataW-1:0] Unbounded = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] ValOne    = DataW'(1);
  localparam logic [DataW-1:0] ValZero   = '0;

  // Product being built by the shared multiplier
  typedef enum logic [1:0] {
    OP_NUM,   // term * num_prev + num_prev2
    OP_DEN,   // term * den_prev + den_prev2
    OP_UPP,   // den_prev * k
    OP_LOW    // den_prev * den_prev + den_prev * k
  } op_e;

  // Partial product pass of a 64x64 wrapping multiply
  typedef enum logic [1:0] {
    STEP_LL,  // low x low, plus addend
    STEP_HL,  // high x low, shifted
    STEP_LH   // low x high, shifted, product complete
  } step_e;

  typedef struct packed {
    logic  load_term;
    logic  mul_en;
    op_e   op;
    step_e step;
    logic  commit;
    logic  emit_prev;
    logic  emit_final;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic final_term;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/cfc_ctrl.sv =====
// Sequencer for the convergent unit: input transfer, multiply passes, result issue.
`timescale 1ns / 1ps

module cfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfc_pkg::sts_t sts_i,
  output cfc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRAP,
    ST_FINAL
  } state_e;

  state_e          state_q;
  cfc_pkg::op_e    op_q;
  cfc_pkg::step_e  step_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_term  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_en     = (state_q == ST_MUL);
    cmd_o.op         = op_q;
    cmd_o.step       = step_q;
    cmd_o.commit     = (state_q == ST_WRAP) && (!sts_i.started || sts_i.out_free);
    cmd_o.emit_prev  = (state_q == ST_WRAP) && sts_i.started && sts_i.out_free;
    cmd_o.emit_final = (state_q == ST_FINAL) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= cfc_pkg::OP_NUM;
      step_q  <= cfc_pkg::STEP_LL;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
            op_q    <= cfc_pkg::OP_NUM;
            step_q  <= cfc_pkg::STEP_LL;
          end
        end
        ST_MUL: begin
          case (step_q)
            cfc_pkg::STEP_LL: step_q <= cfc_pkg::STEP_HL;
            cfc_pkg::STEP_HL: step_q <= cfc_pkg::STEP_LH;
            default: begin
              step_q <= cfc_pkg::STEP_LL;
              case (op_q)
                cfc_pkg::OP_NUM: op_q <= cfc_pkg::OP_DEN;
                cfc_pkg::OP_DEN: begin
                  if (sts_i.started) begin
                    op_q <= cfc_pkg::OP_UPP;
                  end else begin
                    state_q <= ST_WRAP;
                  end
                end
                cfc_pkg::OP_UPP: op_q <= cfc_pkg::OP_LOW;
                default: state_q <= ST_WRAP;
              endcase
            end
          endcase
        end
        ST_WRAP: begin
          if (cmd_o.commit) begin
            state_q <= sts_i.final_term ? ST_FINAL : ST_IDLE;
          end
        end
        ST_FINAL: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/cfc_datapath.sv =====
// Recurrence registers, shared 32x32 multiplier and output register.
`timescale 1ns / 1ps

module cfc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfc_pkg::cmd_t                  cmd_i,
  output cfc_pkg::sts_t                  sts_o,
  input  logic [cfc_pkg::DataW-1:0]      term_i,
  input  logic                           final_term_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cfc_pkg::OutDataW-1:0]   out_data_o,
  output logic                           out_unknown_o,
  output logic                           out_last_o
);

  localparam int unsigned W  = cfc_pkg::DataW;
  localparam int unsigned HW = cfc_pkg::HalfW;

  // recurrence state
  logic [W-1:0] num_prev_q, num_prev2_q, den_prev_q, den_prev2_q, held_q;
  logic         started_q;

  // current term and products
  logic [W-1:0] term_q, h_q, k_q, upp_q, low_q, acc_q, acc_d;
  logic         final_q;

  // output register
  logic         out_valid_q;
  logic [W-1:0] o_quot_q, o_num_q, o_den_q, o_low_q, o_upp_q;
  logic         o_unknown_q, o_last_q;

  logic [W-1:0]  opnd_a, opnd_b, addend;
  logic [HW-1:0] mul_x, mul_y;
  logic [W-1:0]  mul_p;
  logic          out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.op)
      cfc_pkg::OP_NUM: begin
        opnd_a = term_q;     opnd_b = num_prev_q; addend = num_prev2_q;
      end
      cfc_pkg::OP_DEN: begin
        opnd_a = term_q;     opnd_b = den_prev_q; addend = den_prev2_q;
      end
      cfc_pkg::OP_UPP: begin
        opnd_a = den_prev_q; opnd_b = k_q;        addend = cfc_pkg::ValZero;
      end
      default: begin
        opnd_a = den_prev_q; opnd_b = den_prev_q; addend = upp_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.step)
      cfc_pkg::STEP_LL: begin
        mul_x = opnd_a[HW-1:0];  mul_y = opnd_b[HW-1:0];
      end
      cfc_pkg::STEP_HL: begin
        mul_x = opnd_a[W-1:HW];  mul_y = opnd_b[HW-1:0];
      end
      default: begin
        mul_x = opnd_a[HW-1:0];  mul_y = opnd_b[W-1:HW];
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_comb begin
    if (cmd_i.step == cfc_pkg::STEP_LL) begin
      acc_d = mul_p + addend;
    end else begin
      acc_d = acc_q + {mul_p[HW-1:0], {HW{1'b0}}};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_term) begin
      term_q  <= term_i;
      final_q <= final_term_i;
    end
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
      if (cmd_i.step == cfc_pkg::STEP_LH) begin
        case (cmd_i.op)
          cfc_pkg::OP_NUM: h_q   <= acc_d;
          cfc_pkg::OP_DEN: k_q   <= acc_d;
          cfc_pkg::OP_UPP: upp_q <= acc_d;
          default:         low_q <= acc_d;
        endcase
      end
    end
    if (cmd_i.emit_prev) begin
      o_quot_q    <= held_q;
      o_num_q     <= num_prev_q;
      o_den_q     <= den_prev_q;
      o_low_q     <= low_q;
      o_upp_q     <= upp_q;
      o_unknown_q <= 1'b0;
      o_last_q    <= 1'b0;
    end else if (cmd_i.emit_final) begin
      o_quot_q    <= term_q;
      o_num_q     <= h_q;
      o_den_q     <= k_q;
      o_low_q     <= cfc_pkg::Unbounded;
      o_upp_q     <= cfc_pkg::Unbounded;
      o_unknown_q <= 1'b1;
      o_last_q    <= 1'b1;
    end
  end

  // recurrence state, h(-1)=1 h(-2)=0 k(-1)=0 k(-2)=1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_prev_q  <= cfc_pkg::ValOne;
      num_prev2_q <= cfc_pkg::ValZero;
      den_prev_q  <= cfc_pkg::ValZero;
      den_prev2_q <= cfc_pkg::ValOne;
      held_q      <= cfc_pkg::ValZero;
      started_q   <= 1'b0;
    end else if (cmd_i.emit_final) begin
      num_prev_q  <= cfc_pkg::ValOne;
      num_prev2_q <= cfc_pkg::ValZero;
      den_prev_q  <= cfc_pkg::ValZero;
      den_prev2_q <= cfc_pkg::ValOne;
      held_q      <= cfc_pkg::ValZero;
      started_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      num_prev2_q <= num_prev_q;
      den_prev2_q <= den_prev_q;
      num_prev_q  <= h_q;
      den_prev_q  <= k_q;
      held_q      <= term_q;
      started_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_prev || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.started    = started_q;
  assign sts_o.final_term = final_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = {o_upp_q, o_low_q, o_den_q, o_num_q, o_quot_q};
  assign out_unknown_o = o_unknown_q;
  assign out_last_o    = o_last_q;

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_prev || cmd_i.emit_final) |-> out_free)
    else $error("result issued over an untaken result");

  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_prev && cmd_i.emit_final))
    else $error("two results issued in one cycle");

  a_restart_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_final |=> (!started_q && den_prev_q == cfc_pkg::ValZero))
    else $error("state not restarted after final convergent");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_term && (cmd_i.mul_en || cmd_i.commit)))
    else $error("term loaded while a term is in progress");

endmodule

// ===== hdl/continued_fraction_convergents_unit.sv =====
// Top level of the continued fraction convergent unit.
//
//  channel  dir  fields (lowest bit up)
//  s_axis   in   tdata: term[63:0]; tlast: final_term
//  m_axis   out  tdata: quotient, numerator, denominator, lower_bound_product,
//                upper_bound_product (64 bits each); tuser: bounds_unknown;
//                tlast: last_result
//
//  One term at a time. First term of a fraction: transfer, numerator and
//  denominator products, commit; later terms also form the bound products.
//  A final term adds a step to issue the exact convergent. All products use
//  the single shared 32x32 multiplier, three passes per 64-bit wrapping product.
//  Reset restores h(-1)=1, h(-2)=0, k(-1)=0, k(-2)=1. A stalled m_axis holds
//  the unit in its issue step; a new term is taken while a result waits.
`timescale 1ns / 1ps

module continued_fraction_convergents_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cfc_pkg::DataW-1:0]       s_axis_tdata,   // term
  input  logic                            s_axis_tlast,   // final_term
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cfc_pkg::OutDataW-1:0]    m_axis_tdata,   // quotient, numerator,
                                                          // denominator, lower, upper
  output logic [0:0]                      m_axis_tuser,   // bounds_unknown
  output logic                            m_axis_tlast    // last_result
);

  cfc_pkg::cmd_t cmd;
  cfc_pkg::sts_t sts;

  cfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .term_i        (s_axis_tdata),
    .final_term_i  (s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_unknown_o (m_axis_tuser[0]),
    .out_last_o    (m_axis_tlast)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the continued fraction convergent unit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DataW    = cfc_pkg::DataW;
  localparam int unsigned OutDataW = cfc_pkg::OutDataW;

  localparam logic [DataW-1:0] ValOne    = cfc_pkg::ValOne;
  localparam logic [DataW-1:0] ValZero   = cfc_pkg::ValZero;
  localparam logic [DataW-1:0] Unbounded = cfc_pkg::Unbounded;

  localparam int unsigned TermTarget = 750;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdlePct = 21;

  localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinNeg = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] AllOnes = '1;

  // one convergent as it leaves m_axis: {tlast, tuser, tdata}
  typedef struct packed {
    logic             last_result;
    logic             bounds_unknown;
    logic [DataW-1:0] upper_bound_product;
    logic [DataW-1:0] lower_bound_product;
    logic [DataW-1:0] denominator;
    logic [DataW-1:0] numerator;
    logic [DataW-1:0] quotient;
  } conv_t;

  class convergent_board;
    logic [DataW-1:0] h1, h2, k1, k2, q_held;
    bit               begun;
    conv_t            convergents_due[$];
    int unsigned      errors, checked, finals;

    function new();
      restart();
      errors  = 0;
      checked = 0;
      finals  = 0;
    endfunction

    function void restart();
      h1     = ValOne;
      h2     = ValZero;
      k1     = ValZero;
      k2     = ValOne;
      q_held = ValZero;
      begun  = 1'b0;
    endfunction

    function int unsigned pending();
      return convergents_due.size();
    endfunction

    function void note_term(logic [DataW-1:0] a, logic fin);
      logic [DataW-1:0] h, k;
      conv_t            c;
      h = a * h1 + h2;
      k = a * k1 + k2;
      if (begun) begin
        c.quotient            = q_held;
        c.numerator           = h1;
        c.denominator         = k1;
        c.lower_bound_product = k1 * (k1 + k);
        c.upper_bound_product = k1 * k;
        c.bounds_unknown      = 1'b0;
        c.last_result         = 1'b0;
        convergents_due.push_back(c);
      end
      h2     = h1;
      k2     = k1;
      h1     = h;
      k1     = k;
      q_held = a;
      begun  = 1'b1;
      if (fin) begin
        c.quotient            = a;
        c.numerator           = h;
        c.denominator         = k;
        c.lower_bound_product = Unbounded;
        c.upper_bound_product = Unbounded;
        c.bounds_unknown      = 1'b1;
        c.last_result         = 1'b1;
        convergents_due.push_back(c);
        restart();
      end
    endfunction

    function void field_check(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(conv_t got);
      conv_t want;
      if (convergents_due.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result expected none got %h", $time, got);
        return;
      end
      want = convergents_due.pop_front();
      checked++;
      if (want.last_result) finals++;
      field_check("quotient", want.quotient, got.quotient);
      field_check("numerator", want.numerator, got.numerator);
      field_check("denominator", want.denominator, got.denominator);
      field_check("lower_bound_product", want.lower_bound_product, got.lower_bound_product);
      field_check("upper_bound_product", want.upper_bound_product, got.upper_bound_product);
      field_check("bounds_unknown", DataW'(want.bounds_unknown), DataW'(got.bounds_unknown));
      field_check("last_result", DataW'(want.last_result), DataW'(got.last_result));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;

  convergent_board sb;
  bit              tx_idle = 1'b1;
  bit              rx_idle = 1'b1;
  bit              rx_hold_go = 1'b0;
  bit              rx_hold_taken = 1'b0;
  int unsigned     rx_hold = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     terms_sent = 0;
  int unsigned     fractions_sent = 0;

  continued_fraction_convergents_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // transfer monitor: note accepted terms, check accepted convergents
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_term(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(conv_t'({m_axis_tlast, m_axis_tuser, m_axis_tdata}));
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_go && !rx_hold_taken) begin
      rx_hold_taken = 1'b1;
      rx_hold       = HoldCycles;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle && $urandom_range(0, 99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, WatchLimit);
      $display("continued_fraction_convergents_unit: mismatch");
      $finish;
    end
  end

  task automatic send_term(input logic [DataW-1:0] t, input logic fin);
    while (tx_idle && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    terms_sent++;
    if (fin) fractions_sent++;
  endtask

  function automatic logic [DataW-1:0] pick_term();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return DataW'($urandom_range(0, 10));
    if (sel < 50) return -DataW'($urandom_range(1, 10));
    if (sel < 80) return {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       return ValZero;
      1:       return ValOne;
      2:       return AllOnes;
      3:       return MaxPos;
      default: return MinNeg;
    endcase
  endfunction

  initial begin
    int unsigned len;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-term fractions
    send_term(ValZero, 1'b1);
    send_term(MaxPos, 1'b1);
    send_term(MinNeg, 1'b1);
    // pi
    send_term(64'd3, 1'b0);
    send_term(64'd7, 1'b0);
    send_term(64'd15, 1'b0);
    send_term(64'd1, 1'b0);
    send_term(64'd292, 1'b1);
    // extremes and zero quotients, wrapping products
    send_term(AllOnes, 1'b0);
    send_term(AllOnes, 1'b0);
    send_term(MinNeg, 1'b0);
    send_term(MaxPos, 1'b0);
    send_term(ValZero, 1'b1);
    // golden ratio
    repeat (5) send_term(ValOne, 1'b0);
    send_term(ValOne, 1'b1);
    send_term(ValZero, 1'b0);
    send_term(ValZero, 1'b1);
    send_term(MaxPos, 1'b0);
    send_term(MaxPos, 1'b0);
    send_term(MinNeg, 1'b1);

    while (terms_sent < TermTarget) begin
      tx_idle = !(terms_sent >= 250 && terms_sent < 400);
      rx_idle <= tx_idle;
      if (terms_sent >= 550) rx_hold_go <= 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++) send_term(pick_term(), i == len - 1);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d terms in %0d fractions; %0d convergents checked, %0d of them exact finals",
             terms_sent, fractions_sent, sb.checked, sb.finals);
    $display("receiver held off %0d cycles once, idle-free stretch included", HoldCycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("continued_fraction_convergents_unit: match");
    end else begin
      $display("%0d errors, %0d convergents never seen", sb.errors, sb.pending());
      $display("continued_fraction_convergents_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== continued_fraction_convergents_unit.f =====
hdl/cfc_pkg.sv
hdl/cfc_ctrl.sv
hdl/cfc_datapath.sv
hdl/continued_fraction_convergents_unit.sv
tb/sv/tb.sv
